>>> design/bec_pkg.sv
package bec_pkg;

  localparam int COORD_W     = 24;
  localparam int MAX_BOXES   = 64;
  localparam int BOX_IDX_W   = $clog2(MAX_BOXES);
  localparam int BOX_CNT_W   = 7;
  localparam int MAX_SAMPLES = 4096;
  localparam int CNT_W       = 13;
  localparam int STEP_W      = 16;
  localparam int MAG_W       = COORD_W;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int SQ_W        = 2 * MAG_W + 2;
  localparam int LEN_W       = SQ_W / 2;
  localparam int NUM_W       = MAG_W + STEP_W;
  localparam int QUO_W       = STEP_W + 1;
  localparam int ACC_W       = COORD_W + 2;
  localparam int DIST_W      = 28;
  localparam int QUEUE_DEPTH = 2;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [2:0] REG_WALK_STEP     = 3'd0;
  localparam logic [2:0] REG_BOX_COUNT     = 3'd1;
  localparam logic [2:0] REG_BORDER_LOW_X  = 3'd2;
  localparam logic [2:0] REG_BORDER_LOW_Y  = 3'd3;
  localparam logic [2:0] REG_BORDER_LOW_Z  = 3'd4;
  localparam logic [2:0] REG_BORDER_HIGH_X = 3'd5;
  localparam logic [2:0] REG_BORDER_HIGH_Y = 3'd6;
  localparam logic [2:0] REG_BORDER_HIGH_Z = 3'd7;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic                 kind;
    logic [BOX_IDX_W-1:0] box_index;
    coord_t               first_x;
    coord_t               first_y;
    coord_t               first_z;
    coord_t               second_x;
    coord_t               second_y;
    coord_t               second_z;
  } in_item_t;

  typedef struct packed {
    logic             hits_obstacle;
    logic             leaves_border;
    logic [LEN_W-1:0] segment_length;
    logic [CNT_W-1:0] samples_taken;
    logic             truncated;
  } out_item_t;

  typedef struct packed {
    coord_t lo_x;
    coord_t lo_y;
    coord_t lo_z;
    coord_t hi_x;
    coord_t hi_y;
    coord_t hi_z;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  typedef struct packed {
    logic [STEP_W-1:0]    walk_step;
    logic [BOX_CNT_W-1:0] box_count;
    coord_t               low_x;
    coord_t               low_y;
    coord_t               low_z;
    coord_t               high_x;
    coord_t               high_y;
    coord_t               high_z;
  } cfg_t;

  typedef struct packed {
    logic     is_check;
    in_item_t item;
  } q_entry_t;

endpackage

>>> design/bec_item_if.sv
interface bec_item_if;
  import bec_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> design/bec_result_if.sv
interface bec_result_if;
  import bec_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> design/bec_ram.sv
module bec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/bec_front.sv
module bec_front (
  input  logic               clk,
  input  logic               rst,
  bec_item_if.sink           item,
  output bec_pkg::q_entry_t  qd,
  output logic               q_valid,
  input  logic               q_pop
);
  import bec_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t          slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [FILL_W-1:0] fill;
  logic              push;
  logic              pop;

  assign item.ready = (fill != FILL_W'(QUEUE_DEPTH));
  assign push = item.valid && item.ready;
  assign q_valid = (fill != '0);
  assign pop = q_pop && q_valid;
  assign qd = slots[rptr];

  // tag each beat so the back end knows a table write from a segment
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr].is_check <= item.payload.kind;
      slots[wptr].item <= item.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end
endmodule

>>> design/bec_sqrt.sv
module bec_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bec_pkg::SQ_W-1:0]  val,
  output logic                      done,
  output logic [bec_pkg::LEN_W-1:0] root
);
  import bec_pkg::*;

  localparam int CNT_BITS = $clog2(LEN_W + 1);

  logic [SQ_W-1:0]     rem;
  logic [SQ_W-1:0]     acc;
  logic [SQ_W-1:0]     bitv;
  logic [SQ_W-1:0]     trial;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;

  assign trial = acc + bitv;
  assign root = acc[LEN_W-1:0];

  // one root bit per pass from two radicand bits, one pass per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= val;
      acc <= '0;
      bitv <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        acc <= (acc >> 1) + bitv;
      end else begin
        acc <= acc >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_BITS'(1));
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_BITS'(LEN_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule

>>> design/bec_div.sv
module bec_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bec_pkg::NUM_W-1:0] num,
  input  logic [bec_pkg::LEN_W-1:0] den,
  output logic                      done,
  output logic [bec_pkg::NUM_W-1:0] quo,
  output logic [bec_pkg::LEN_W-1:0] rem
);
  import bec_pkg::*;

  localparam int CNT_BITS = $clog2(NUM_W + 1);

  logic [LEN_W:0]      trial;
  logic                ge;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;

  assign trial = {rem, quo[NUM_W-1]};
  assign ge = (trial >= {1'b0, den});

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? LEN_W'(trial - {1'b0, den}) : trial[LEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_BITS'(1));
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_BITS'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule

>>> design/bec_back.sv
module bec_back (
  input  logic              clk,
  input  logic              rst,
  input  bec_pkg::q_entry_t qd,
  input  logic              q_valid,
  output logic              q_pop,
  input  bec_pkg::cfg_t     cfg,
  bec_result_if.source      result
);
  import bec_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQ     = 4'd1;
  localparam logic [3:0] S_ROOT   = 4'd2;
  localparam logic [3:0] S_MUL    = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_PT     = 4'd5;
  localparam logic [3:0] S_BORDER = 4'd6;
  localparam logic [3:0] S_SCAN   = 4'd7;
  localparam logic [3:0] S_ADV    = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]               state;
  coord_t                   fa [3];
  coord_t                   sb [3];
  logic signed [DIFF_W-1:0] dw [3];
  coord_t                   a [3];
  logic [MAG_W-1:0]         mag [3];
  logic [2:0]               neg;
  logic [1:0]               ax;
  logic [SQ_W-1:0]          sq;
  logic [2*MAG_W-1:0]       sqp;
  logic [LEN_W-1:0]         len;
  logic [NUM_W-1:0]         num;
  logic [QUO_W-1:0]         qinc [3];
  logic [LEN_W-1:0]         rinc [3];
  logic [ACC_W-1:0]         qacc [3];
  logic [LEN_W-1:0]         racc [3];
  logic [LEN_W:0]           rsum [3];
  logic signed [ACC_W-1:0]  p [3];
  logic [CNT_W-1:0]         k;
  logic [DIST_W-1:0]        walked;
  logic [STEP_W-1:0]        step;
  logic [BOX_CNT_W-1:0]     nbox;
  logic [BOX_CNT_W-1:0]     bi;
  logic                     pend;
  logic                     hit;
  logic                     leave;
  logic                     trunc;
  logic                     go;
  logic                     root_start;
  logic                     root_done;
  logic [LEN_W-1:0]         root_val;
  logic                     div_start;
  logic                     div_done;
  logic [NUM_W-1:0]         div_quo;
  logic [LEN_W-1:0]         div_rem;
  logic                     we;
  box_t                     wbox;
  logic [BOX_W-1:0]         rdata;
  box_t                     bx;
  logic                     in_box;
  logic                     outside;
  logic                     res_valid;
  out_item_t                res;

  assign fa[0] = qd.item.first_x;
  assign fa[1] = qd.item.first_y;
  assign fa[2] = qd.item.first_z;
  assign sb[0] = qd.item.second_x;
  assign sb[1] = qd.item.second_y;
  assign sb[2] = qd.item.second_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dw[i] = DIFF_W'(sb[i]) - DIFF_W'(fa[i]);
      rsum[i] = {1'b0, racc[i]} + {1'b0, rinc[i]};
    end
  end

  assign step = (cfg.walk_step == '0) ? STEP_W'(1) : cfg.walk_step;
  assign nbox = (cfg.box_count > BOX_CNT_W'(MAX_BOXES)) ? BOX_CNT_W'(MAX_BOXES) : cfg.box_count;
  assign sqp = mag[ax] * mag[ax];

  assign q_pop = (state == S_IDLE) && q_valid;
  assign we = q_pop && !qd.is_check;
  assign wbox = '{lo_x: qd.item.first_x, lo_y: qd.item.first_y, lo_z: qd.item.first_z,
                  hi_x: qd.item.second_x, hi_y: qd.item.second_y, hi_z: qd.item.second_z};

  bec_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_boxes (
    .clk   (clk),
    .we    (we),
    .waddr (qd.item.box_index),
    .wdata (wbox),
    .raddr (bi[BOX_IDX_W-1:0]),
    .rdata (rdata)
  );

  assign root_start = (state == S_ROOT) && !go;
  assign div_start = (state == S_DIV) && !go;

  bec_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .val   (sq),
    .done  (root_done),
    .root  (root_val)
  );

  bec_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (len),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign bx = box_t'(rdata);
  assign in_box = (p[0] > bx.lo_x) && (p[0] < bx.hi_x) &&
                  (p[1] > bx.lo_y) && (p[1] < bx.hi_y) &&
                  (p[2] > bx.lo_z) && (p[2] < bx.hi_z);
  assign outside = (p[0] < cfg.low_x) || (p[0] > cfg.high_x) ||
                   (p[1] < cfg.low_y) || (p[1] > cfg.high_y) ||
                   (p[2] < cfg.low_z) || (p[2] > cfg.high_z);

  assign result.valid = res_valid;
  assign result.payload = res;

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_valid && qd.is_check) begin
          for (int i = 0; i < 3; i++) begin
            a[i] <= fa[i];
            neg[i] <= dw[i][DIFF_W-1];
            mag[i] <= dw[i][DIFF_W-1] ? MAG_W'(-dw[i]) : MAG_W'(dw[i]);
          end
          sq <= '0;
          ax <= '0;
          hit <= 1'b0;
          leave <= 1'b0;
          trunc <= 1'b0;
        end
      end
      S_SQ: begin
        sq <= sq + SQ_W'(sqp);
        ax <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
      end
      S_ROOT: begin
        if (root_done) begin
          len <= root_val;
          k <= '0;
          walked <= '0;
          for (int i = 0; i < 3; i++) begin
            qacc[i] <= '0;
            racc[i] <= '0;
            qinc[i] <= '0;
            rinc[i] <= '0;
          end
        end
      end
      S_MUL: begin
        num <= mag[ax] * step;
      end
      S_DIV: begin
        if (div_done) begin
          qinc[ax] <= div_quo[QUO_W-1:0];
          rinc[ax] <= div_rem;
          ax <= ax + 2'd1;
        end
      end
      S_PT: begin
        if (!(k != '0 && walked >= DIST_W'(len)) && k == CNT_W'(MAX_SAMPLES)) begin
          trunc <= 1'b1;
        end
        for (int i = 0; i < 3; i++) begin
          p[i] <= ACC_W'(a[i]) + (neg[i] ? -$signed(qacc[i]) : $signed(qacc[i]));
        end
      end
      S_BORDER: begin
        leave <= leave | outside;
        bi <= '0;
        pend <= 1'b0;
      end
      S_SCAN: begin
        if (bi < nbox) begin
          bi <= bi + 1'b1;
          pend <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
        if (pend && in_box) begin
          hit <= 1'b1;
        end
      end
      S_ADV: begin
        k <= k + 1'b1;
        walked <= walked + DIST_W'(step);
        // carry the fractional part of each offset into the quotient
        for (int i = 0; i < 3; i++) begin
          if (rsum[i] >= {1'b0, len}) begin
            racc[i] <= LEN_W'(rsum[i] - {1'b0, len});
            qacc[i] <= qacc[i] + ACC_W'(qinc[i]) + ACC_W'(1);
          end else begin
            racc[i] <= rsum[i][LEN_W-1:0];
            qacc[i] <= qacc[i] + ACC_W'(qinc[i]);
          end
        end
      end
      S_DONE: begin
        if (!res_valid || result.ready) begin
          res.hits_obstacle <= hit;
          res.leaves_border <= leave;
          res.segment_length <= len;
          res.samples_taken <= k;
          res.truncated <= trunc;
        end
      end
      default: begin
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      go <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid && qd.is_check) begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (ax == 2'd2) begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          go <= !root_done;
          if (root_done) begin
            state <= (root_val == '0) ? S_PT : S_MUL;
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          go <= !div_done;
          if (div_done) begin
            state <= (ax == 2'd2) ? S_PT : S_MUL;
          end
        end
        S_PT: begin
          if ((k != '0 && walked >= DIST_W'(len)) || k == CNT_W'(MAX_SAMPLES)) begin
            state <= S_DONE;
          end else begin
            state <= S_BORDER;
          end
        end
        S_BORDER: begin
          // skip the table once a hit is known or when no boxes are in use
          state <= (hit || nbox == '0) ? S_ADV : S_SCAN;
        end
        S_SCAN: begin
          if (!(bi < nbox) && !pend) begin
            state <= S_ADV;
          end
        end
        S_ADV: begin
          state <= S_PT;
        end
        S_DONE: begin
          if (!res_valid || result.ready) begin
            res_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

>>> design/box_obstacle_edge_check.sv
// Checks segments against a table of up to 64 axis-aligned obstacle boxes and
// the map border. A beat of kind 0 writes one table entry as the idle back end
// pops it; a beat of kind 1 checks the segment and returns one result. A check
// first finds the length (25-step square root) and the per-axis step increments
// (three 40-step divisions), then for each sample reads the box table one
// entry per cycle from a single RAM port; once a hit is found the table scan is
// skipped. A check takes up to 4096 samples. A two-entry queue lets the input
// side keep accepting until it is full while the back end works, and a finished
// result is held in an output register until taken. Configuration is an APB
// slave with registers at byte offsets 0x00 through 0x1C.
module box_obstacle_edge_check (
  input  logic                           clk,
  input  logic                           rst,
  bec_item_if.sink                       item,
  bec_result_if.source                   result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bec_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bec_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bec_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import bec_pkg::*;

  cfg_t       cfg;
  q_entry_t   qd;
  logic       q_valid;
  logic       q_pop;
  logic       wr;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && pready;
  assign ridx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.walk_step <= STEP_W'(256);
      cfg.box_count <= '0;
      cfg.low_x <= {1'b1, {(COORD_W-1){1'b0}}};
      cfg.low_y <= {1'b1, {(COORD_W-1){1'b0}}};
      cfg.low_z <= {1'b1, {(COORD_W-1){1'b0}}};
      cfg.high_x <= {1'b0, {(COORD_W-1){1'b1}}};
      cfg.high_y <= {1'b0, {(COORD_W-1){1'b1}}};
      cfg.high_z <= {1'b0, {(COORD_W-1){1'b1}}};
    end else if (wr) begin
      case (ridx)
        REG_WALK_STEP:     cfg.walk_step <= pwdata[STEP_W-1:0];
        REG_BOX_COUNT:     cfg.box_count <= pwdata[BOX_CNT_W-1:0];
        REG_BORDER_LOW_X:  cfg.low_x <= pwdata[COORD_W-1:0];
        REG_BORDER_LOW_Y:  cfg.low_y <= pwdata[COORD_W-1:0];
        REG_BORDER_LOW_Z:  cfg.low_z <= pwdata[COORD_W-1:0];
        REG_BORDER_HIGH_X: cfg.high_x <= pwdata[COORD_W-1:0];
        REG_BORDER_HIGH_Y: cfg.high_y <= pwdata[COORD_W-1:0];
        REG_BORDER_HIGH_Z: cfg.high_z <= pwdata[COORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_WALK_STEP:     prdata = APB_DATA_W'(cfg.walk_step);
      REG_BOX_COUNT:     prdata = APB_DATA_W'(cfg.box_count);
      REG_BORDER_LOW_X:  prdata = APB_DATA_W'(cfg.low_x);
      REG_BORDER_LOW_Y:  prdata = APB_DATA_W'(cfg.low_y);
      REG_BORDER_LOW_Z:  prdata = APB_DATA_W'(cfg.low_z);
      REG_BORDER_HIGH_X: prdata = APB_DATA_W'(cfg.high_x);
      REG_BORDER_HIGH_Y: prdata = APB_DATA_W'(cfg.high_y);
      REG_BORDER_HIGH_Z: prdata = APB_DATA_W'(cfg.high_z);
      default:           prdata = '0;
    endcase
  end

  bec_front u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .qd      (qd),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  bec_back u_back (
    .clk     (clk),
    .rst     (rst),
    .qd      (qd),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .cfg     (cfg),
    .result  (result)
  );

  a_trunc_count: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.payload.truncated |->
      result.payload.samples_taken == CNT_W'(MAX_SAMPLES))
    else $error("truncated result without full sample count");

  a_some_sample: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.payload.samples_taken != '0)
    else $error("result with no samples");

  a_point_check: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.payload.segment_length == '0 |->
      result.payload.samples_taken == CNT_W'(1))
    else $error("zero-length segment not checked as one point");
endmodule
